>>> rtl/gcd_pkg.sv
// Shared types, constants and elaboration-time helpers for the great circle distance block.
// Depends on nothing; used by every cell and by the top level.
package gcd_pkg;

    // CORDIC word width, Q48 angles and coordinates with sign headroom
    localparam int CW = 52;
    // Square root: 62-bit radicand, 31-bit root
    localparam int SQ_STEPS = 31;
    localparam int SQ_RAD_W = 2 * SQ_STEPS;

    localparam logic [63:0] PI_Q48       = 64'h0003_243F_6A88_85A3;
    localparam logic [63:0] TWO_PI_Q48   = PI_Q48 << 1;
    localparam logic [63:0] HALF_PI_Q48  = PI_Q48 >> 1;
    localparam logic [63:0] GAIN_INV_Q48 = 64'h9B74_EDA8 << 16;
    localparam logic [63:0] D2R_Q36      = PI_Q48 / 64'd737280;
    localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
    localparam logic [63:0] PI_Q30       = PI_Q48 >> 18;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flag;
    } cordic_t;

    typedef struct packed {
        logic [SQ_RAD_W-1:0] rad;
        logic [SQ_STEPS+1:0] rem;
        logic [SQ_STEPS-1:0] root;
    } sqrt_t;

    // Bit-serial long division of a constant by a small constant divisor
    function automatic logic [63:0] div_small(input logic [63:0] num, input logic [7:0] den);
        logic [63:0] q;
        logic [8:0]  rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[7:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q48: series in Q60 with truncated terms, rounded to Q48
    function automatic logic [63:0] atan_q48(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          k;
        sum = '0;
        k   = 0;
        if (i == 0) begin
            return PI_Q48 >> 2;
        end
        while (i * (2 * k + 1) <= 60) begin
            term = div_small(64'd1 << (60 - i * (2 * k + 1)), 8'(2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - term;
            end
            else begin
                sum = sum + term;
            end
            k = k + 1;
        end
        return (sum + 64'd2048) >> 12;
    endfunction

endpackage

>>> rtl/gcd_red_cell.sv
// One doubling step of the angle reduction modulo 2*pi (Q48 residue).
// Depends on gcd_pkg for the 2*pi constant.
module gcd_red_cell (
    input  logic        clk,
    input  logic [51:0] r_in,
    output logic [51:0] r_out
);

    logic [51:0] r_reg;
    logic [51:0] r_next;
    logic [51:0] dbl;

    // Double and drop one period when it overflows
    always_comb
    begin
        dbl = {r_in[50:0], 1'b0};
        if (dbl >= 52'(gcd_pkg::TWO_PI_Q48))
        begin
            r_next = dbl - 52'(gcd_pkg::TWO_PI_Q48);
        end
        else
        begin
            r_next = dbl;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
    end

    assign r_out = r_reg;

endmodule

>>> rtl/gcd_cordic_cell.sv
// One CORDIC micro-rotation, rotation mode (sign of z) or vectoring mode (sign of y).
// Depends on gcd_pkg for the word type and the arctangent constants.
module gcd_cordic_cell #(
    parameter int IDX    = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic             clk,
    input  gcd_pkg::cordic_t d_in,
    output gcd_pkg::cordic_t d_out
);

    localparam logic signed [gcd_pkg::CW-1:0] ANG = gcd_pkg::CW'(gcd_pkg::atan_q48(IDX));

    gcd_pkg::cordic_t q_reg;
    gcd_pkg::cordic_t q_next;
    logic signed [gcd_pkg::CW-1:0] dx;
    logic signed [gcd_pkg::CW-1:0] dy;
    logic sigma;

    // Rotate toward zero angle (rotation) or toward the x axis (vectoring)
    always_comb
    begin
        dx     = d_in.y >>> IDX;
        dy     = d_in.x >>> IDX;
        sigma  = VECTOR ? d_in.y[gcd_pkg::CW-1] : ~d_in.z[gcd_pkg::CW-1];
        q_next = d_in;
        if (sigma)
        begin
            q_next.x = d_in.x - dx;
            q_next.y = d_in.y + dy;
            q_next.z = d_in.z - ANG;
        end
        else
        begin
            q_next.x = d_in.x + dx;
            q_next.y = d_in.y - dy;
            q_next.z = d_in.z + ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign d_out = q_reg;

endmodule

>>> rtl/gcd_sqrt_cell.sv
// One digit of a restoring integer square root: two radicand bits in, one root bit out.
// Depends on gcd_pkg for the square root word type.
module gcd_sqrt_cell (
    input  logic           clk,
    input  gcd_pkg::sqrt_t d_in,
    output gcd_pkg::sqrt_t d_out
);

    localparam int RW = gcd_pkg::SQ_STEPS + 2;
    localparam int SN = gcd_pkg::SQ_STEPS;

    gcd_pkg::sqrt_t q_reg;
    gcd_pkg::sqrt_t q_next;
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;

    // Bring down two bits and try the next root bit
    always_comb
    begin
        cur        = {d_in.rem, d_in.rad[gcd_pkg::SQ_RAD_W-1 -: 2]};
        trial      = {2'b00, d_in.root, 2'b01};
        q_next.rad = {d_in.rad[gcd_pkg::SQ_RAD_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            q_next.rem  = RW'(cur - trial);
            q_next.root = {d_in.root[SN-2:0], 1'b1};
        end
        else
        begin
            q_next.rem  = RW'(cur);
            q_next.root = {d_in.root[SN-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign d_out = q_reg;

endmodule

>>> rtl/great_circle_distance.sv
// Top level: haversine central angle as a chain of reduction, CORDIC and square root cells.
// Depends on gcd_pkg, gcd_red_cell, gcd_cordic_cell and gcd_sqrt_cell.
//
//  channel   signals                               direction  handshake
//  request   start, busy, lon_a, lat_a, lon_b, lat_b   in     start && !busy
//  result    done, central_angle                       out    done strobe, one cycle
//  config    cfg_we, cfg_data (angle_unit)             in     cfg_we
//
// One request is taken every cycle; busy is always low.
// Latency is set by the reduction cells, the two CORDIC chains and the 31 square root
// cells, with the conversion, fold, product and output registers between them.
// Reset clears the valid chain and angle_unit; data cells carry no reset.
// The receiver cannot stall, so nothing in the chain ever holds.
module great_circle_distance #(
    parameter int ANGLE_FRAC_BITS = 22,
    parameter int CORDIC_STEPS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] lon_a,
    input  logic [31:0] lat_a,
    input  logic [31:0] lon_b,
    input  logic [31:0] lat_b,
    input  logic        cfg_we,
    input  logic        cfg_data,
    output logic        done,
    output logic [31:0] central_angle
);

    localparam int NRED   = 47 - ANGLE_FRAC_BITS;
    localparam int V_FOLD = 3 + NRED;
    localparam int V_ROT  = V_FOLD + CORDIC_STEPS;
    localparam int V_SC   = V_ROT + 1;
    localparam int V_P1   = V_SC + 1;
    localparam int V_H    = V_P1 + 3;
    localparam int V_SQ   = V_H + gcd_pkg::SQ_STEPS;
    localparam int V_VEC  = V_SQ + CORDIC_STEPS;
    localparam int V_OUT  = V_VEC + 1;
    localparam int LAT    = V_OUT + 1;
    localparam int CW     = gcd_pkg::CW;

    logic            angle_unit_reg;
    logic [LAT-1:0]  vld_reg;
    logic            accept;

    logic [31:0]     raw_reg   [4];
    logic            sgn_reg   [4];
    logic [63:0]     prod_reg  [4];
    logic            unit_reg;
    logic [31:0]     ang_reg   [4];
    logic [51:0]     red_s     [4][NRED+1];
    gcd_pkg::cordic_t fold_reg [4];
    gcd_pkg::cordic_t rot_s    [4][CORDIC_STEPS+1];
    logic signed [31:0] sc_reg [4];
    logic signed [63:0] t1p_reg, t2p_reg, ccp_reg;
    logic signed [31:0] t1r_reg, t2r_reg, ccr_reg;
    logic signed [31:0] t1c_reg;
    logic signed [63:0] mp_reg;
    logic [30:0]     h_reg;
    gcd_pkg::sqrt_t  sq_s     [2][gcd_pkg::SQ_STEPS+1];
    gcd_pkg::cordic_t vec_s   [CORDIC_STEPS+1];
    logic [31:0]     out_reg;

    assign accept = start && !busy;
    assign busy   = 1'b0;

    // Hold the angle unit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_unit_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            angle_unit_reg <= cfg_data;
        end
    end

    // Advance the valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], accept};
        end
    end

    // Take the request; scale magnitudes by pi/180 in Q36
    always_ff @(posedge clk)
    begin
        logic [31:0] v [4];
        logic [31:0] m;
        v[0] = lat_a;
        v[1] = lat_b;
        v[2] = lon_a;
        v[3] = lon_b;
        for (int i = 0; i < 4; i++)
        begin
            m           = v[i][31] ? (32'd0 - v[i]) : v[i];
            raw_reg[i]  <= v[i];
            sgn_reg[i]  <= v[i][31];
            prod_reg[i] <= 64'(m) * gcd_pkg::D2R_Q36;
        end
        unit_reg <= angle_unit_reg;
    end

    // Round degree conversion, or pass radians
    always_ff @(posedge clk)
    begin
        logic [31:0] rq;
        for (int i = 0; i < 4; i++)
        begin
            rq = 32'((prod_reg[i] + (64'd1 << 35)) >> 36);
            if (unit_reg)
            begin
                ang_reg[i] <= sgn_reg[i] ? (32'd0 - rq) : rq;
            end
            else
            begin
                ang_reg[i] <= raw_reg[i];
            end
        end
    end

    // Form magnitudes: half differences as is, latitudes doubled to share the step count
    always_ff @(posedge clk)
    begin
        logic signed [32:0] dlat;
        logic signed [32:0] dlon;
        logic signed [32:0] la;
        logic signed [32:0] lb;
        dlat = 33'(signed'(ang_reg[0])) - 33'(signed'(ang_reg[1]));
        dlon = 33'(signed'(ang_reg[3])) - 33'(signed'(ang_reg[2]));
        la   = 33'(signed'(ang_reg[0]));
        lb   = 33'(signed'(ang_reg[1]));
        red_s[0][0] <= 52'(dlat[32] ? -dlat : dlat);
        red_s[1][0] <= 52'(dlon[32] ? -dlon : dlon);
        red_s[2][0] <= {18'd0, 33'(la[32] ? -la : la), 1'b0};
        red_s[3][0] <= {18'd0, 33'(lb[32] ? -lb : lb), 1'b0};
    end

    // Reduction, fold and rotation chains, one lane per angle
    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        for (genvar i = 0; i < NRED; i++)
        begin : g_red
            gcd_red_cell u_red (
                .clk   (clk),
                .r_in  (red_s[l][i]),
                .r_out (red_s[l][i+1])
            );
        end

        // Fold into the first quadrant, mark negated cosine
        always_ff @(posedge clk)
        begin
            logic [51:0] r;
            logic        neg;
            r   = red_s[l][NRED];
            neg = 1'b0;
            if (r > 52'(gcd_pkg::PI_Q48))
            begin
                r = 52'(gcd_pkg::TWO_PI_Q48) - r;
            end
            if (r > 52'(gcd_pkg::HALF_PI_Q48))
            begin
                r   = 52'(gcd_pkg::PI_Q48) - r;
                neg = 1'b1;
            end
            fold_reg[l].x    <= CW'(gcd_pkg::GAIN_INV_Q48);
            fold_reg[l].y    <= '0;
            fold_reg[l].z    <= signed'(r);
            fold_reg[l].flag <= neg;
        end

        assign rot_s[l][0] = fold_reg[l];

        for (genvar i = 0; i < CORDIC_STEPS; i++)
        begin : g_rot
            gcd_cordic_cell #(
                .IDX    (i),
                .VECTOR (1'b0)
            ) u_rot (
                .clk   (clk),
                .d_in  (rot_s[l][i]),
                .d_out (rot_s[l][i+1])
            );
        end
    end

    // Round sine and cosine to Q30
    always_ff @(posedge clk)
    begin
        logic signed [CW-1:0] v;
        for (int l = 0; l < 4; l++)
        begin
            v = (l < 2) ? rot_s[l][CORDIC_STEPS].y : rot_s[l][CORDIC_STEPS].x;
            v = (v + CW'(64'd1 << 17)) >>> 18;
            if (l >= 2 && rot_s[l][CORDIC_STEPS].flag)
            begin
                sc_reg[l] <= 32'(-v);
            end
            else
            begin
                sc_reg[l] <= 32'(v);
            end
        end
    end

    // Square sines, multiply cosines
    always_ff @(posedge clk)
    begin
        t1p_reg <= 64'(sc_reg[0]) * 64'(sc_reg[0]);
        t2p_reg <= 64'(sc_reg[1]) * 64'(sc_reg[1]);
        ccp_reg <= 64'(sc_reg[2]) * 64'(sc_reg[3]);
    end

    // Round products to Q30
    always_ff @(posedge clk)
    begin
        t1r_reg <= 32'((t1p_reg + 64'sd536870912) >>> 30);
        t2r_reg <= 32'((t2p_reg + 64'sd536870912) >>> 30);
        ccr_reg <= 32'((ccp_reg + 64'sd536870912) >>> 30);
    end

    // Weight the longitude term by the cosines
    always_ff @(posedge clk)
    begin
        t1c_reg <= t1r_reg;
        mp_reg  <= 64'(ccr_reg) * 64'(t2r_reg);
    end

    // Sum and clamp the haversine to [0, 1]
    always_ff @(posedge clk)
    begin
        logic signed [34:0] hs;
        hs = 35'(t1c_reg) + 35'((mp_reg + 64'sd536870912) >>> 30);
        if (hs < 0)
        begin
            h_reg <= '0;
        end
        else if (hs > 35'(gcd_pkg::ONE_Q30))
        begin
            h_reg <= 31'(gcd_pkg::ONE_Q30);
        end
        else
        begin
            h_reg <= 31'(hs);
        end
    end

    // Square roots of h and 1 - h
    assign sq_s[0][0] = '{rad: {1'b0, h_reg, 30'd0}, rem: '0, root: '0};
    assign sq_s[1][0] = '{rad: {1'b0, 31'(31'(gcd_pkg::ONE_Q30) - h_reg), 30'd0},
                          rem: '0, root: '0};

    for (genvar s = 0; s < 2; s++)
    begin : g_sq
        for (genvar j = 0; j < gcd_pkg::SQ_STEPS; j++)
        begin : g_step
            gcd_sqrt_cell u_sq (
                .clk   (clk),
                .d_in  (sq_s[s][j]),
                .d_out (sq_s[s][j+1])
            );
        end
    end

    // Vectoring chain: atan2(sqrt(h), sqrt(1 - h))
    assign vec_s[0] = '{x: CW'({sq_s[1][gcd_pkg::SQ_STEPS].root, 16'd0}),
                        y: CW'({sq_s[0][gcd_pkg::SQ_STEPS].root, 16'd0}),
                        z: '0, flag: 1'b0};

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        gcd_cordic_cell #(
            .IDX    (i),
            .VECTOR (1'b1)
        ) u_vec (
            .clk   (clk),
            .d_in  (vec_s[i]),
            .d_out (vec_s[i+1])
        );
    end

    // Double, round to Q30 and clamp to [0, pi]
    always_ff @(posedge clk)
    begin
        logic signed [CW:0] d;
        d = (signed'({vec_s[CORDIC_STEPS].z, 1'b0}) +
             signed'((CW+1)'(64'd1 << 17))) >>> 18;
        if (d < 0)
        begin
            out_reg <= '0;
        end
        else if (d > (CW+1)'(gcd_pkg::PI_Q30))
        begin
            out_reg <= 32'(gcd_pkg::PI_Q30);
        end
        else
        begin
            out_reg <= 32'(d);
        end
    end

    assign done          = vld_reg[LAT-1];
    assign central_angle = out_reg;

`ifndef ASSERT_OFF
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> central_angle <= 32'(gcd_pkg::PI_Q30))
        else $error("central angle above pi");

    a_h_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[V_H] |-> h_reg <= 31'(gcd_pkg::ONE_Q30))
        else $error("haversine above one");

    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[V_FOLD] |-> (!fold_reg[0].z[CW-1] &&
                             fold_reg[0].z <= CW'(gcd_pkg::HALF_PI_Q48)))
        else $error("folded angle outside first quadrant");

    a_unit_stable: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> unit_reg == angle_unit_reg)
        else $error("angle unit changed under a request");
`endif

endmodule

>>> tb/tb_great_circle_distance.sv
// Self-checking testbench for great_circle_distance: drives point-pair requests,
// predicts each central angle with a local haversine/CORDIC model, checks the done strobes.
// Depends on gcd_pkg and the great_circle_distance RTL.
module tb_great_circle_distance;

    localparam int     FRAC      = 22;
    localparam int     STEPS     = 32;
    localparam int     LATENCY   = 41 + (47 - FRAC) + 2 * STEPS;
    localparam int     CYCLE_CAP = 400000;
    localparam logic [31:0] A_PI  = 32'd13176795;   // pi in Q9.22
    localparam logic [31:0] A_HP  = 32'd6588397;    // pi/2 in Q9.22
    localparam logic [31:0] A_180 = 32'd754974720;  // 180 in Q9.22
    localparam logic [31:0] A_90  = 32'd377487360;  // 90 in Q9.22

    typedef enum logic { UNIT_RAD = 1'b0, UNIT_DEG = 1'b1 } unit_t;

    typedef struct {
        unit_t       unit;
        logic [31:0] lon_a;
        logic [31:0] lat_a;
        logic [31:0] lon_b;
        logic [31:0] lat_b;
    } pair_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] lon_a = '0;
    logic [31:0] lat_a = '0;
    logic [31:0] lon_b = '0;
    logic [31:0] lat_b = '0;
    logic        cfg_we = 1'b0;
    logic        cfg_data = 1'b0;
    logic        done;
    logic [31:0] central_angle;

    logic [31:0] angle_q[$];
    longint      atan_lut[STEPS];
    unit_t       unit_now = UNIT_RAD;
    int          err_cnt = 0;
    int          req_cnt = 0;
    int          res_cnt = 0;
    int          cycle_cnt = 0;
    int          idle_pct = 0;

    great_circle_distance #(.ANGLE_FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .lon_a(lon_a), .lat_a(lat_a), .lon_b(lon_b), .lat_b(lat_b),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .done(done), .central_angle(central_angle)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP)
        begin
            $display("tb_great_circle_distance: errors");
            $finish;
        end
    end

    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // atan(2^-i) in Q48 from the truncated Q60 series
    function automatic longint atan_entry(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          k;
        acc = '0;
        if (i == 0)
            return longint'(gcd_pkg::PI_Q48 >> 2);
        for (k = 0; i * (2 * k + 1) <= 60; k++)
        begin
            term = (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return longint'((acc + 64'd2048) >> 12);
    endfunction

    // Fold a magnitude into [0, pi/2] and rotate; sine magnitude and signed cosine in Q30
    function automatic void sin_cos_q30(input logic [63:0] mag, input int frac,
                                        output longint sn, output longint cs);
        logic [63:0] r;
        logic        flip;
        longint      x, y, z, dx, dy;
        int          k;
        flip = 1'b0;
        r = mag % gcd_pkg::TWO_PI_Q48;
        for (k = frac; k < 48; k++)
        begin
            r = r << 1;
            if (r >= gcd_pkg::TWO_PI_Q48)
                r = r - gcd_pkg::TWO_PI_Q48;
        end
        if (r > gcd_pkg::PI_Q48)
            r = gcd_pkg::TWO_PI_Q48 - r;
        if (r > gcd_pkg::HALF_PI_Q48)
        begin
            r = gcd_pkg::PI_Q48 - r;
            flip = 1'b1;
        end
        x = longint'(gcd_pkg::GAIN_INV_Q48);
        y = 0;
        z = longint'(r);
        for (k = 0; k < STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - atan_lut[k];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atan_lut[k];
            end
        end
        sn = round_shift(y, 18);
        cs = round_shift(x, 18);
        if (flip)
            cs = -cs;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint to_radians(input logic [31:0] raw, input unit_t unit);
        longint      v;
        logic [63:0] m;
        v = longint'(signed'(raw));
        if (unit == UNIT_RAD)
            return v;
        m = (v < 0) ? -v : v;
        m = (m * gcd_pkg::D2R_Q36 + (64'd1 << 35)) >> 36;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Haversine central angle in Q2.30
    function automatic logic [31:0] central_angle_of(input pair_t p);
        longint lna, lta, lnb, ltb;
        longint sl, sn, ca, cb, unused, t1, t2, cc, h, x, y, z, dx, dy, d;
        int     k;
        lna = to_radians(p.lon_a, p.unit);
        lta = to_radians(p.lat_a, p.unit);
        lnb = to_radians(p.lon_b, p.unit);
        ltb = to_radians(p.lat_b, p.unit);
        sin_cos_q30(magnitude(lta - ltb), FRAC + 1, sl, unused);
        sin_cos_q30(magnitude(lnb - lna), FRAC + 1, sn, unused);
        sin_cos_q30(magnitude(lta), FRAC, unused, ca);
        sin_cos_q30(magnitude(ltb), FRAC, unused, cb);
        t1 = round_shift(sl * sl, 30);
        t2 = round_shift(sn * sn, 30);
        cc = round_shift(ca * cb, 30);
        h  = t1 + round_shift(cc * t2, 30);
        if (h < 0)
            h = 0;
        if (h > longint'(gcd_pkg::ONE_Q30))
            h = longint'(gcd_pkg::ONE_Q30);
        y = longint'(floor_sqrt(64'(h) << 30)) * 65536;
        x = longint'(floor_sqrt((gcd_pkg::ONE_Q30 - h) << 30)) * 65536;
        z = 0;
        for (k = 0; k < STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (y >= 0)
            begin
                x = x + dx; y = y - dy; z = z + atan_lut[k];
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - atan_lut[k];
            end
        end
        d = round_shift(2 * z, 18);
        if (d < 0)
            d = 0;
        if (d > longint'(gcd_pkg::PI_Q30))
            d = longint'(gcd_pkg::PI_Q30);
        return d[31:0];
    endfunction

    // Check each strobed result against the oldest predicted angle
    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            res_cnt++;
            if (angle_q.size() == 0)
            begin
                $error("central_angle: unexpected result 0x%08h", central_angle);
                err_cnt++;
            end
            else if (central_angle !== angle_q[0])
            begin
                $error("central_angle: expected 0x%08h actual 0x%08h",
                       angle_q[0], central_angle);
                err_cnt++;
                void'(angle_q.pop_front());
            end
            else
                void'(angle_q.pop_front());
        end
    end

    // Present one request from a rising edge and hold it until accepted
    task automatic send_pair(input pair_t p);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        lon_a <= p.lon_a;
        lat_a <= p.lat_a;
        lon_b <= p.lon_b;
        lat_b <= p.lat_b;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        angle_q.push_back(central_angle_of(p));
        req_cnt++;
    endtask

    // Drain the pipeline, then write angle_unit while idle
    task automatic set_unit(input unit_t u);
        start <= 1'b0;
        while (angle_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= u;
        @(posedge clk);
        cfg_we   <= 1'b0;
        unit_now = u;
    endtask

    function automatic logic [31:0] rand_angle(input bit is_lat, input unit_t u);
        int span;
        if ($urandom_range(3) == 0)
            return $urandom;
        if (u == UNIT_DEG)
            span = is_lat ? A_90 : A_180;
        else
            span = is_lat ? A_HP : A_PI;
        return $urandom_range(2 * span) - span;
    endfunction

    function automatic pair_t rand_pair(input unit_t u);
        pair_t p;
        int    kind;
        kind    = $urandom_range(9);
        p.unit  = u;
        p.lon_a = rand_angle(1'b0, u);
        p.lat_a = rand_angle(1'b1, u);
        p.lon_b = rand_angle(1'b0, u);
        p.lat_b = rand_angle(1'b1, u);
        // near-identical points
        if (kind == 0)
        begin
            p.lon_b = p.lon_a + $urandom_range(15) - 7;
            p.lat_b = p.lat_a + $urandom_range(15) - 7;
        end
        // near-antipodal points
        else if (kind == 1)
        begin
            p.lon_b = p.lon_a + ((u == UNIT_DEG) ? A_180 : A_PI) + $urandom_range(7) - 3;
            p.lat_b = -p.lat_a + $urandom_range(7) - 3;
        end
        return p;
    endfunction

    pair_t dir_tab[16] = '{
        '{UNIT_RAD, 32'd0, 32'd0, 32'd0, 32'd0},
        '{UNIT_RAD, 32'd1000000, 32'd2000000, 32'd1000000, 32'd2000000},
        '{UNIT_RAD, 32'd0, 32'd0, A_PI, 32'd0},
        '{UNIT_RAD, 32'd0, A_HP, 32'd0, -A_HP},
        '{UNIT_RAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
        '{UNIT_RAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
        '{UNIT_RAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF},
        '{UNIT_RAD, 32'd0, 3 * A_HP, A_PI, -3 * A_HP},
        '{UNIT_RAD, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF},
        '{UNIT_DEG, 32'd0, 32'd0, 32'd0, 32'd0},
        '{UNIT_DEG, A_90, A_90 >> 1, A_90, A_90 >> 1},
        '{UNIT_DEG, 32'd0, 32'd0, A_180, 32'd0},
        '{UNIT_DEG, 32'd0, A_90, 32'd0, -A_90},
        '{UNIT_DEG, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000},
        '{UNIT_DEG, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000},
        '{UNIT_DEG, -A_180, 2 * A_90, A_180, -2 * A_90}
    };

    initial
    begin
        int    i;
        int    seg;
        unit_t u;
        for (i = 0; i < STEPS; i++)
            atan_lut[i] = atan_entry(i);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_unit(UNIT_RAD);

        // Directed table: extremes, identical, antipodal, wrapped angles, both units
        for (i = 0; i < 16; i++)
        begin
            if (dir_tab[i].unit != unit_now)
                set_unit(dir_tab[i].unit);
            send_pair(dir_tab[i]);
        end

        // Random segments: sender idles 25%, then 86%, then never; unit alternates
        for (seg = 0; seg < 6; seg++)
        begin
            u = (seg % 2 == 0) ? UNIT_DEG : UNIT_RAD;
            set_unit(u);
            idle_pct = (seg < 2) ? 25 : ((seg < 4) ? 86 : 0);
            for (i = 0; i < 92; i++)
                send_pair(rand_pair(u));
        end

        start <= 1'b0;
        while (angle_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        $display("Covered %0d point pairs and %0d results in radian and degree modes,",
                 req_cnt, res_cnt);
        $display("with extremes, wrapped, identical and antipodal points under sender gaps.");
        if (err_cnt == 0)
            $display("tb_great_circle_distance: clean");
        else
            $display("tb_great_circle_distance: errors");
        $finish;
    end

endmodule
